// ===== hdl/gdfs_pkg.sv =====
// shared types and constants for the nearest-first depth-first walk block
// field widths, request codes, controller states, command/status bundles
// no dependencies
package gdfs_pkg;

    localparam int NODE_W          = 5;
    localparam int IN_WT_W         = 16;
    localparam int HOP_W           = 16;
    localparam int MILE_W          = 21;
    localparam int MAX_NODES_DEF   = 32;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int S_TDATA_W       = 32;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 48;
    localparam int M_TUSER_W       = 2;

    localparam logic [MILE_W-1:0] MILE_MAX = '1;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_CMP,
        ST_ADD_WR2,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_STEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic add_load;
        logic add_wr_ab;
        logic add_wr_ba;
        logic run_init;
        logic nf_load;
        logic scan_init;
        logic scan_run;
        logic pop;
        logic take;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic add_ok;
        logic self_loop;
        logic run_ok;
        logic add_better;
        logic clr_done;
        logic scan_done;
        logic found;
        logic depth_one;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [HOP_W-1:0]  hop_distance;
        logic [MILE_W-1:0] total_mileage;
        logic              is_start;
        logic              status;
        logic              last_item;
    } t_result;

endpackage

// ===== hdl/gdfs_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module gdfs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gdfs_ctrl.sv =====
// controller state machine for the depth-first walk block
// depends on gdfs_pkg (states, request codes, command and status bundles)
module gdfs_ctrl
    import gdfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [1:0] i_req_type,
    input  t_sts       i_sts,
    output logic       o_req_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_req_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ADD: begin
                            if (i_sts.add_ok && !i_sts.self_loop) n_state = ST_ADD_CMP;
                        end
                        REQ_RUN:   n_state = i_sts.run_ok ? ST_SCAN_INIT : ST_FINISH;
                        REQ_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_CMP:   n_state = i_sts.add_better ? ST_ADD_WR2 : ST_IDLE;
            ST_ADD_WR2:   n_state = ST_IDLE;
            ST_SCAN_INIT: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_sts.scan_done) n_state = ST_STEP;
            end
            ST_STEP: begin
                if (i_sts.found) begin
                    if (i_sts.out_free) n_state = ST_SCAN_INIT;
                end else if (i_sts.depth_one) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SCAN_INIT;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ADD: o_cmd.add_load = 1'b1;
                        REQ_RUN: begin
                            o_cmd.run_init = i_sts.run_ok;
                            o_cmd.nf_load  = !i_sts.run_ok;
                        end
                        REQ_CLEAR: o_cmd.clr_start = 1'b1;
                        default:   o_cmd = '0;
                    endcase
                end
            end
            ST_ADD_CMP:   o_cmd.add_wr_ab = i_sts.add_better;
            ST_ADD_WR2:   o_cmd.add_wr_ba = 1'b1;
            ST_SCAN_INIT: o_cmd.scan_init = 1'b1;
            ST_SCAN:      o_cmd.scan_run = 1'b1;
            ST_STEP: begin
                o_cmd.take = i_sts.found && i_sts.out_free;
                o_cmd.pop  = !i_sts.found;
            end
            ST_FINISH: o_cmd.flush = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/gdfs_dp.sv =====
// datapath: adjacency matrix ram, presence and visited marks, walk stack,
// neighbor scan with best-candidate registers, pending and output result registers
// depends on gdfs_pkg and gdfs_ram
module gdfs_dp
    import gdfs_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [NODE_W-1:0]  i_node_a,
    input  logic [NODE_W-1:0]  i_node_b,
    input  logic [IN_WT_W-1:0] i_weight,
    input  logic               i_out_ready,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output t_result            o_result
);

    localparam int NL    = (MAX_NODES < 32) ? MAX_NODES : 32;
    localparam int NW    = $clog2(NL);
    localparam int DW    = $clog2(NL + 1);
    localparam int WB    = WEIGHT_BITS;
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;
    // mileage adder wide enough for a full weight on top of the saturated sum
    localparam int SW    = ((WB > MILE_W) ? WB : MILE_W) + 1;
    localparam logic [NW:0]       NL_V  = (NW + 1)'(NL);
    localparam logic [NODE_W:0]   NL_N  = (NODE_W + 1)'(NL);

    // matrix entry: valid flag above the weight
    logic [WB:0]       ram_rdata;
    logic [WB:0]       ram_wdata;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic              ram_we;

    logic [NW-1:0]     a_idx, b_idx;
    logic              a_ok, b_ok;
    logic [WB-1:0]     w_in;

    logic [AW-1:0]     r_clr,     n_clr;
    logic [NL-1:0]     r_present, n_present;
    logic [NL-1:0]     r_visited, n_visited;
    logic [NW-1:0]     r_a,       n_a;
    logic [NW-1:0]     r_b,       n_b;
    logic [WB-1:0]     r_w,       n_w;
    logic [DW-1:0]     r_depth,   n_depth;
    logic [NW-1:0]     r_u,       n_u;
    logic [NW:0]       r_v,       n_v;
    logic              r_cmp_vld, n_cmp_vld;
    logic [NW-1:0]     r_cmp_v,   n_cmp_v;
    logic              r_found,   n_found;
    logic [NW-1:0]     r_best_v,  n_best_v;
    logic [WB-1:0]     r_best_w,  n_best_w;
    logic [MILE_W-1:0] r_mile,    n_mile;
    t_result           r_pend,    n_pend;
    t_result           r_out,     n_out;
    logic              r_ovalid,  n_ovalid;

    logic [NW-1:0]     r_stack [NL];
    logic [DW-1:0]     top_idx;
    logic [SW-1:0]     mile_sum;
    logic [MILE_W-1:0] mile_sat;
    logic              cand;
    logic              out_free;

    assign a_ok  = ({1'b0, i_node_a} < NL_N);
    assign b_ok  = ({1'b0, i_node_b} < NL_N);
    assign a_idx = i_node_a[NW-1:0];
    assign b_idx = i_node_b[NW-1:0];
    assign w_in  = WB'(i_weight);

    assign top_idx  = r_depth - DW'(1);
    assign mile_sum = SW'(r_mile) + SW'(r_best_w);
    assign mile_sat = (mile_sum > SW'(MILE_MAX)) ? MILE_MAX : mile_sum[MILE_W-1:0];
    assign out_free = !r_ovalid || i_out_ready;

    // ties keep the earlier (lower) index since the compare is strict
    assign cand = r_cmp_vld && ram_rdata[WB] && !r_visited[r_cmp_v]
                  && (!r_found || (ram_rdata[WB-1:0] < r_best_w));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        if (i_cmd.add_wr_ab) begin
            ram_we    = 1'b1;
            ram_waddr = {r_a, r_b};
            ram_wdata = {1'b1, r_w};
        end else if (i_cmd.add_wr_ba) begin
            ram_we    = 1'b1;
            ram_waddr = {r_b, r_a};
            ram_wdata = {1'b1, r_w};
        end else if (i_cmd.clr_step) begin
            ram_we    = 1'b1;
        end
        ram_raddr = i_cmd.add_load ? {a_idx, b_idx} : {r_u, r_v[NW-1:0]};
    end

    gdfs_ram #(
        .WIDTH (WB + 1),
        .DEPTH (DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_clr     = r_clr;
        n_present = r_present;
        n_visited = r_visited;
        n_a       = r_a;
        n_b       = r_b;
        n_w       = r_w;
        n_depth   = r_depth;
        n_u       = r_u;
        n_v       = r_v;
        n_cmp_vld = 1'b0;
        n_cmp_v   = r_cmp_v;
        n_found   = r_found;
        n_best_v  = r_best_v;
        n_best_w  = r_best_w;
        n_mile    = r_mile;
        n_pend    = r_pend;
        n_out     = r_out;
        n_ovalid  = r_ovalid && !i_out_ready;

        if (i_cmd.clr_start) begin
            n_clr     = '0;
            n_present = '0;
        end
        if (i_cmd.clr_step) begin
            n_clr = r_clr + AW'(1);
        end
        if (i_cmd.add_load) begin
            n_a = a_idx;
            n_b = b_idx;
            n_w = w_in;
            if (a_ok && b_ok) begin
                n_present[a_idx] = 1'b1;
                n_present[b_idx] = 1'b1;
            end
        end
        if (i_cmd.run_init) begin
            n_visited        = '0;
            n_visited[a_idx] = 1'b1;
            n_depth          = DW'(1);
            n_mile           = '0;
            n_pend           = '0;
            n_pend.to_node   = i_node_a;
            n_pend.is_start  = 1'b1;
        end
        if (i_cmd.nf_load) begin
            n_pend         = '0;
            n_pend.to_node = i_node_a;
            n_pend.status  = 1'b1;
        end
        if (i_cmd.scan_init) begin
            n_u     = r_stack[top_idx[NW-1:0]];
            n_v     = '0;
            n_found = 1'b0;
        end
        if (i_cmd.scan_run) begin
            // address goes out this cycle, entry is compared in the next cycle
            if (r_v < NL_V) begin
                n_v       = r_v + (NW + 1)'(1);
                n_cmp_vld = 1'b1;
                n_cmp_v   = r_v[NW-1:0];
            end
            if (cand) begin
                n_found  = 1'b1;
                n_best_v = r_cmp_v;
                n_best_w = ram_rdata[WB-1:0];
            end
        end
        if (i_cmd.pop) begin
            n_depth = r_depth - DW'(1);
        end
        if (i_cmd.take) begin
            n_out                = r_pend;
            n_ovalid             = 1'b1;
            n_pend               = '0;
            n_pend.from_node     = NODE_W'(r_u);
            n_pend.to_node       = NODE_W'(r_best_v);
            n_pend.hop_distance  = HOP_W'(r_best_w);
            n_pend.total_mileage = mile_sat;
            n_mile               = mile_sat;
            n_visited[r_best_v]  = 1'b1;
            n_depth              = r_depth + DW'(1);
        end
        if (i_cmd.flush) begin
            n_out           = r_pend;
            n_out.last_item = 1'b1;
            n_ovalid        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_present <= '0;
            r_visited <= '0;
            r_depth   <= '0;
            r_mile    <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_clr     <= n_clr;
            r_present <= n_present;
            r_visited <= n_visited;
            r_depth   <= n_depth;
            r_mile    <= n_mile;
            r_cmp_vld <= n_cmp_vld;
            r_found   <= n_found;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_w      <= n_w;
        r_u      <= n_u;
        r_v      <= n_v;
        r_cmp_v  <= n_cmp_v;
        r_best_v <= n_best_v;
        r_best_w <= n_best_w;
        r_pend   <= n_pend;
        r_out    <= n_out;
        if (i_cmd.run_init) begin
            r_stack[0] <= a_idx;
        end else if (i_cmd.take) begin
            r_stack[r_depth[NW-1:0]] <= r_best_v;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.add_ok     = a_ok && b_ok;
        o_sts.self_loop  = (i_node_a == i_node_b);
        o_sts.run_ok     = a_ok && r_present[a_idx];
        o_sts.add_better = !ram_rdata[WB] || (r_w < ram_rdata[WB-1:0]);
        o_sts.clr_done   = (r_clr == '1);
        o_sts.scan_done  = (r_v == NL_V) && !r_cmp_vld;
        o_sts.found      = r_found;
        o_sts.depth_one  = (r_depth == DW'(1));
        o_sts.out_free   = out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_result    = r_out;

endmodule

// ===== hdl/graph_dfs_nearest_first.sv =====
// top level: depth-first walk taking the nearest unvisited neighbor first
// add edge: taken in idle, then a compare state and, if lighter, a second write state; clear: writes every matrix entry
// walk: each node scan does one matrix read per neighbor, and a walk that visits
// V nodes scans 2V-1 times; not-found answers go straight to the finish state
// reset (sync, active low) starts a matrix clearing pass during which no request is taken;
// one finished result waits in the output register
module graph_dfs_nearest_first
    import gdfs_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // node_a, node_b, weight
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // from_node, to_node, hop_distance, total_mileage
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // is_start, status
    output logic                 m_axis_tlast
);

    t_cmd    cmd;
    t_sts    sts;
    t_result result;

    gdfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_type  (s_axis_tuser[1:0]),
        .i_sts       (sts),
        .o_req_ready (s_axis_tready),
        .o_cmd       (cmd)
    );

    gdfs_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_node_a    (s_axis_tdata[4:0]),
        .i_node_b    (s_axis_tdata[9:5]),
        .i_weight    (s_axis_tdata[25:10]),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result)
    );

    assign m_axis_tdata = {1'b0, result.total_mileage, result.hop_distance,
                           result.to_node, result.from_node};
    assign m_axis_tuser = {result.status, result.is_start};
    assign m_axis_tlast = result.last_item;

endmodule

// ===== test/tb_graph_dfs_nearest_first.sv =====
// testbench for graph_dfs_nearest_first: directed, pressure and random request streams
// predicts every walk result in its own adjacency model and checks the output stream
// depends on gdfs_pkg and graph_dfs_nearest_first
module tb_graph_dfs_nearest_first;
    import gdfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam int         NODE_COUNT   = MAX_NODES_DEF;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // adjacency model of the graph as loaded so far
    logic        link_ok   [NODE_COUNT][NODE_COUNT];
    logic [15:0] link_wt   [NODE_COUNT][NODE_COUNT];
    logic        node_seen [NODE_COUNT];
    t_result     expected_hops [$];

    int fault_count     = 0;
    int requests_sent   = 0;
    int src_idle_pct    = 0;
    int sink_idle_pct   = 0;
    int hold_off_cycles = 0;
    bit quiet_tail      = 1'b0;

    graph_dfs_nearest_first u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),    // node_a, node_b, weight
        .s_axis_tuser  (s_tuser),    // req_type
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),    // from_node, to_node, hop_distance, total_mileage
        .m_axis_tuser  (m_tuser),    // is_start, status
        .m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("graph_dfs_nearest_first regression: fail");
        $finish;
    end

    function automatic void clear_graph();
        foreach (link_ok[i, j]) begin
            link_ok[i][j] = 1'b0;
            link_wt[i][j] = '0;
        end
        foreach (node_seen[i]) node_seen[i] = 1'b0;
    endfunction

    function automatic void predict_walk(logic [4:0] start);
        logic       seen [NODE_COUNT];
        logic [4:0] path [NODE_COUNT];
        logic [4:0] here;
        int         depth;
        int         best;
        int         hop_wt;
        int         total;
        t_result    rec;
        t_result    walk [$];
        if (!node_seen[start]) begin
            rec = '0;
            rec.to_node   = start;
            rec.status    = 1'b1;
            rec.last_item = 1'b1;
            expected_hops = {expected_hops, rec};
            return;
        end
        foreach (seen[i]) seen[i] = 1'b0;
        seen[start] = 1'b1;
        path[0]     = start;
        depth       = 1;
        total       = 0;
        rec = '0;
        rec.to_node  = start;
        rec.is_start = 1'b1;
        walk = {walk, rec};
        while (depth > 0) begin
            here   = path[depth-1];
            best   = -1;
            hop_wt = 0;
            // strict less-than keeps the lower index on equal weights
            for (int v = 0; v < NODE_COUNT; v++) begin
                if (link_ok[here][v] && !seen[v] && (best < 0 || link_wt[here][v] < hop_wt)) begin
                    best   = v;
                    hop_wt = link_wt[here][v];
                end
            end
            if (best < 0) begin
                depth--;
            end else begin
                total += hop_wt;
                if (total > MILE_MAX) total = MILE_MAX;
                seen[best]  = 1'b1;
                path[depth] = 5'(best);
                depth++;
                rec = '0;
                rec.from_node     = here;
                rec.to_node       = 5'(best);
                rec.hop_distance  = 16'(hop_wt);
                rec.total_mileage = 21'(total);
                walk = {walk, rec};
            end
        end
        walk[walk.size()-1].last_item = 1'b1;
        foreach (walk[i]) expected_hops = {expected_hops, walk[i]};
    endfunction

    function automatic void predict_request(logic [1:0] req, logic [4:0] a, logic [4:0] b,
                                            logic [15:0] w);
        case (req)
            REQ_CLEAR: begin
                clear_graph();
            end
            REQ_ADD: begin
                node_seen[a] = 1'b1;
                node_seen[b] = 1'b1;
                if (a != b && (!link_ok[a][b] || w < link_wt[a][b])) begin
                    link_ok[a][b] = 1'b1;
                    link_ok[b][a] = 1'b1;
                    link_wt[a][b] = w;
                    link_wt[b][a] = w;
                end
            end
            REQ_RUN: begin
                predict_walk(a);
            end
            default: ;
        endcase
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_request(logic [1:0] req, logic [4:0] a, logic [4:0] b, logic [15:0] w);
        if (!quiet_tail && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, w, b, a};
        do @(posedge i_clk); while (!s_tready);
        predict_request(req, a, b, w);
        if (req != REQ_RESERVED) requests_sent++;
    endtask

    function automatic logic [15:0] pick_weight(bit narrow);
        if (narrow) return 16'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    // one random graph: optional clear, a spanning tree, extra edges, then walks; or a short burst of random requests
    task automatic run_scenario();
        logic [4:0] pool [NODE_COUNT];
        logic [4:0] tmp;
        int         j;
        int         k;
        bit         narrow;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                send_request(2'($urandom_range(0, 3)), 5'($urandom), 5'($urandom), 16'($urandom));
            end
            return;
        end
        if ($urandom_range(0, 3) != 0) send_request(REQ_CLEAR, 5'($urandom), 5'($urandom),
                                                    16'($urandom));
        for (int i = 0; i < NODE_COUNT; i++) pool[i] = 5'(i);
        for (int i = NODE_COUNT - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        k      = ($urandom_range(0, 9) == 0) ? NODE_COUNT : $urandom_range(2, 10);
        narrow = $urandom_range(0, 1);
        for (int i = 1; i < k; i++) begin
            if ($urandom_range(0, 1))
                send_request(REQ_ADD, pool[i], pool[$urandom_range(0, i-1)], pick_weight(narrow));
            else
                send_request(REQ_ADD, pool[$urandom_range(0, i-1)], pool[i], pick_weight(narrow));
        end
        // extras may repeat an edge or land on a self-loop
        repeat ($urandom_range(0, k/2 + 1)) begin
            send_request(REQ_ADD, pool[$urandom_range(0, k-1)], pool[$urandom_range(0, k-1)],
                         pick_weight(narrow));
        end
        repeat ($urandom_range(1, 2)) begin
            send_request(REQ_RUN, pool[$urandom_range(0, k-1)], 5'($urandom), 16'($urandom));
        end
        if (k < NODE_COUNT && $urandom_range(0, 3) == 0)
            send_request(REQ_RUN, pool[$urandom_range(k, NODE_COUNT-1)], 5'($urandom),
                         16'($urandom));
    endtask

    task automatic test_directed();
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        send_request(REQ_RUN,   5'd0,  5'd0,  16'h0000);    // empty graph
        send_request(REQ_ADD,   5'd0,  5'd31, 16'hFFFF);
        send_request(REQ_ADD,   5'd31, 5'd0,  16'hFFFF);
        send_request(REQ_ADD,   5'd0,  5'd5,  16'h0000);
        send_request(REQ_ADD,   5'd5,  5'd5,  16'h04D2);    // self-loop
        send_request(REQ_ADD,   5'd3,  5'd7,  16'd100);
        send_request(REQ_ADD,   5'd3,  5'd7,  16'd200);     // heavier repeat is dropped
        send_request(REQ_ADD,   5'd7,  5'd3,  16'd50);      // lighter repeat wins
        send_request(REQ_ADD,   5'd0,  5'd2,  16'd10);
        send_request(REQ_ADD,   5'd0,  5'd4,  16'd10);      // tie with node 2
        send_request(REQ_ADD,   5'd2,  5'd3,  16'd10);
        send_request(REQ_ADD,   5'd9,  5'd9,  16'h0000);    // isolated node
        send_request(REQ_RUN,   5'd0,  5'd31, 16'hFFFF);
        send_request(REQ_RUN,   5'd31, 5'd0,  16'h0000);
        send_request(REQ_RUN,   5'd9,  5'd0,  16'h0000);
        send_request(REQ_RUN,   5'd20, 5'd0,  16'h0000);    // never loaded
        send_request(REQ_RESERVED, 5'd31, 5'd31, 16'hFFFF);
        send_request(REQ_RUN,   5'd7,  5'd0,  16'h0000);
        send_request(REQ_CLEAR, 5'd31, 5'd31, 16'hFFFF);
        send_request(REQ_RUN,   5'd0,  5'd0,  16'h0000);
        send_request(REQ_ADD,   5'd31, 5'd30, 16'h8000);
        send_request(REQ_RUN,   5'd30, 5'd0,  16'h0000);
    endtask

    // long walk held at the output while more requests queue up behind it
    task automatic test_output_backpressure();
        logic [4:0] order [NODE_COUNT];
        logic [4:0] tmp;
        int         j;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_request(REQ_CLEAR, 5'd0, 5'd0, 16'h0000);
        for (int i = 0; i < NODE_COUNT; i++) order[i] = 5'(i);
        for (int i = NODE_COUNT - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 1; i < NODE_COUNT; i++)
            send_request(REQ_ADD, order[i-1], order[i], pick_weight(1'b0));
        repeat (6) send_request(REQ_ADD, 5'($urandom), 5'($urandom), pick_weight(1'b0));
        hold_off_cycles = 3000;
        send_request(REQ_RUN, order[0], 5'd0, 16'h0000);
        repeat (6) send_request(REQ_ADD, 5'($urandom), 5'($urandom), pick_weight(1'b0));
        send_request(REQ_RUN, order[NODE_COUNT-1], 5'd0, 16'h0000);
        send_request(REQ_RUN, 5'($urandom), 5'd0, 16'h0000);
    endtask

    task automatic test_random_graphs(int budget);
        while (requests_sent < budget) begin
            case ($urandom_range(0, 2))
                0:       src_idle_pct = 0;
                1:       src_idle_pct = 15;
                default: src_idle_pct = 45;
            endcase
            sink_idle_pct = 10 * $urandom_range(0, 5);
            run_scenario();
        end
    endtask

    task automatic test_streaming_tail(int budget);
        quiet_tail = 1'b1;
        while (requests_sent < budget) run_scenario();
    endtask

    initial begin : sink_ready
        int span;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                span            = hold_off_cycles;
                hold_off_cycles = 0;
                m_tready <= 1'b0;
                repeat (span - 1) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 99) < sink_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_hops.size() == 0) begin
                $error("unexpected result: to_node %0d", m_tdata[9:5]);
                fault_count++;
            end else begin
                want = expected_hops.pop_front();
                check_field("from_node",     want.from_node,     m_tdata[4:0]);
                check_field("to_node",       want.to_node,       m_tdata[9:5]);
                check_field("hop_distance",  want.hop_distance,  m_tdata[25:10]);
                check_field("total_mileage", want.total_mileage, m_tdata[46:26]);
                check_field("is_start",      want.is_start,      m_tuser[0]);
                check_field("status",        want.status,        m_tuser[1]);
                check_field("last_item",     want.last_item,     m_tlast);
            end
        end
    end

    initial begin
        int waited;
        clear_graph();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_output_backpressure();
        test_random_graphs(350);
        test_streaming_tail(410);
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_hops.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_hops.size() != 0) begin
            $error("%0d expected results never arrived", expected_hops.size());
            fault_count++;
        end
        repeat (2500) @(posedge i_clk);
        if (fault_count == 0)
            $display("graph_dfs_nearest_first regression: pass");
        else
            $display("graph_dfs_nearest_first regression: fail");
        $finish;
    end

endmodule
